### rtl/core/drs_pkg.sv
// drs_pkg: shared types and constants for the deduplicating request stack
// no dependencies; used by drs_ctrl and dedup_request_stack_top
`default_nettype none

package drs_pkg;

  localparam int TYPE_W  = 2;
  localparam int CHUNK_W = 16;
  localparam int CNT_W   = 5;
  localparam int OUT_W   = 24;

  // request codes
  localparam logic [TYPE_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [TYPE_W-1:0] OP_POP    = 2'd1;
  localparam logic [TYPE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [TYPE_W-1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic               push_ok;
    logic [CHUNK_W-1:0] popped_value;
    logic [CNT_W-1:0]   entry_count;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/drs_ram.sv
// drs_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module drs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/drs_ctrl.sv
// drs_ctrl: request sequencer with one shared compare unit scanning the entry ram
// depends on drs_pkg and drs_ram
`default_nettype none

module drs_ctrl #(
  parameter int CAPACITY = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_vld_i,
  output logic                             req_rdy_o,
  input  wire logic [drs_pkg::TYPE_W-1:0]  req_type_i,
  input  wire logic [drs_pkg::CHUNK_W-1:0] chunk_i,
  output logic                             res_vld_o,
  input  wire logic                        res_rdy_i,
  output drs_pkg::res_t                    res_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_POPDAT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [drs_pkg::TYPE_W-1:0]   op_q, op_d;
  logic [drs_pkg::CHUNK_W-1:0]  chunk_q, chunk_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                pidx_q, pidx_d;
  logic                         pend_q, pend_d;
  logic                         ok_q, ok_d;
  logic [drs_pkg::CHUNK_W-1:0]  pop_q, pop_d;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [drs_pkg::CHUNK_W-1:0]  ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [drs_pkg::CHUNK_W-1:0]  ram_rdata;

  logic                         match;
  logic [CW-1:0]                count_m1;

  drs_ram #(
    .WIDTH (drs_pkg::CHUNK_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare unit: ram read data is registered and lags its address, which pidx keeps
  assign match    = pend_q && (ram_rdata == chunk_q);
  assign count_m1 = count_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    chunk_d   = chunk_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pend_d    = pend_q;
    ok_d      = ok_q;
    pop_d     = pop_q;
    ram_we    = 1'b0;
    ram_waddr = pidx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_vld_i) begin
          op_d    = req_type_i;
          chunk_d = chunk_i;
          ok_d    = 1'b1;
          pop_d   = '0;
          idx_d   = '0;
          pend_d  = 1'b0;
          case (req_type_i)
            drs_pkg::OP_PUSH: begin
              if (count_q >= CW'(CAPACITY)) begin
                ok_d    = 1'b0;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            drs_pkg::OP_REMOVE: begin
              state_d = S_SCAN;
            end
            drs_pkg::OP_POP: begin
              state_d = (count_q != '0) ? S_POP : S_DONE;
            end
            drs_pkg::OP_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (match) begin
          if (op_q == drs_pkg::OP_REMOVE) begin
            idx_d   = pidx_q + CW'(1);
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end else begin
            pend_d  = 1'b0;
            state_d = S_DONE;
          end
        end else if (idx_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          idx_d  = idx_q + CW'(1);
        end else if (!pend_q) begin
          // whole store searched, no match
          if (op_q == drs_pkg::OP_PUSH) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = chunk_q;
            count_d   = count_q + CW'(1);
          end
          state_d = S_DONE;
        end else begin
          pend_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // move entry idx-1 down one slot per cycle
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_q < count_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q - CW'(1);
          idx_d  = idx_q + CW'(1);
        end else begin
          pend_d  = 1'b0;
          count_d = count_m1;
          state_d = S_DONE;
        end
      end

      S_POP: begin
        ram_raddr = count_m1[AW-1:0];
        state_d   = S_POPDAT;
      end

      S_POPDAT: begin
        pop_d   = ram_rdata;
        count_d = count_m1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_rdy_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    chunk_q <= chunk_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    ok_q    <= ok_d;
    pop_q   <= pop_d;
  end

  assign req_rdy_o          = (state_q == S_IDLE);
  assign res_vld_o          = (state_q == S_DONE);
  assign res_o.push_ok      = ok_q;
  assign res_o.popped_value = pop_q;
  assign res_o.entry_count  = drs_pkg::CNT_W'(count_q);

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_refuse_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && !res_o.push_ok) |-> (count_q == CW'(CAPACITY)))
    else $error("push refused while store not full");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && (res_o.popped_value != '0)) |-> (op_q == drs_pkg::OP_POP))
    else $error("nonzero popped value on non-pop request");

  a_wr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < AW'(CAPACITY - 1) || ram_waddr == AW'(CAPACITY - 1)))
    else $error("ram write beyond capacity");

  a_shift_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (count_q != '0))
    else $error("compaction on empty store");
`endif

endmodule

`default_nettype wire

### rtl/core/dedup_request_stack_top.sv
// dedup_request_stack_top: deduplicating lifo set of chunk numbers, stream ports
// depends on drs_pkg, drs_ctrl (which holds drs_ram)
//
// usage
//   s_axis carries one request word: tuser the operation (push, pop, remove,
//   clear), tdata the chunk number. each request gives exactly one m_axis word:
//   push_ok, the popped value and the entry count after the request.
// sequencing
//   one request at a time, s_axis_tready low while the sequencer works. push and
//   remove search the entry ram with one compare unit, one entry per cycle, up to
//   the first match; a remove then compacts the tail one entry per cycle.
//   a pop reads the newest entry; clear and a refused push touch no ram. tready
//   returns with m_axis_tvalid.
// reset
//   rst_ni clears the count and the handshake state; entry ram is not cleared,
//   only entries below the count are ever read.
// stalls
//   the output register holds a result while m_axis_tready is low; the next
//   request can still be taken and worked on, and it waits at the end of its
//   work until the output register frees.
`default_nettype none

module dedup_request_stack_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // s_axis_tdata: [15:0] chunk_number
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [drs_pkg::CHUNK_W-1:0]         s_axis_tdata,
  // s_axis_tuser: [1:0] req_type
  input  wire logic [drs_pkg::TYPE_W-1:0]          s_axis_tuser,
  // m_axis_tdata: [0] push_ok, [16:1] popped_value, [21:17] entry_count, [23:22] zero
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [drs_pkg::OUT_W-1:0]           m_axis_tdata
);

  logic          res_vld;
  logic          res_take;
  drs_pkg::res_t res;

  logic                       out_vld_q, out_vld_d;
  logic [drs_pkg::OUT_W-1:0]  out_data_q, out_data_d;

  drs_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_vld_i  (s_axis_tvalid),
    .req_rdy_o  (s_axis_tready),
    .req_type_i (s_axis_tuser),
    .chunk_i    (s_axis_tdata),
    .res_vld_o  (res_vld),
    .res_rdy_i  (res_take),
    .res_o      (res)
  );

  // output register takes a result when empty or draining this cycle
  assign res_take = res_vld && (!out_vld_q || m_axis_tready);

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (res_take) begin
      out_vld_d  = 1'b1;
      out_data_d = {2'b00, res.entry_count, res.popped_value, res.push_ok};
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### tb/sv/dedup_request_stack_top_test.sv
// dedup_request_stack_top_test: self-checking bench for the deduplicating lifo set
// drives requests on s_axis, predicts every result word and checks m_axis
// depends on drs_pkg and dedup_request_stack_top
`timescale 1ns / 1ps

module dedup_request_stack_top_test;

  localparam int CAPACITY    = 16;
  localparam int RAND_ITEMS  = 1200;
  localparam int CALM_TAIL   = 150;
  localparam int POOL_SIZE   = 24;
  localparam int MAX_REPORTS = 10;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [drs_pkg::CHUNK_W-1:0]  s_axis_tdata;   // [15:0] chunk_number
  logic [drs_pkg::TYPE_W-1:0]   s_axis_tuser;   // [1:0] req_type
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // [0] push_ok, [16:1] popped_value, [21:17] count
  logic [drs_pkg::OUT_W-1:0]    m_axis_tdata;

  // one directed stimulus row; reps > 1 repeats the row with chunk stepped by step
  typedef struct {
    logic [drs_pkg::TYPE_W-1:0]  op;
    logic [drs_pkg::CHUNK_W-1:0] chunk;
    int                          reps;
    int                          step;
    bit                          typed;
    drs_pkg::res_t               res;
  } stim_row_t;

  logic [drs_pkg::CHUNK_W-1:0] held_q[$];          // predicted store contents, oldest first
  drs_pkg::res_t               pending_results_q[$];
  logic [drs_pkg::CHUNK_W-1:0] chunk_pool[POOL_SIZE];
  int                          mismatch_cnt;
  bit                          calm;               // no idling on either side while set
  int                          stall_left;

  dedup_request_stack_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // apply one request to the predicted store and return its result word
  task automatic predict_stack_result(input logic [drs_pkg::TYPE_W-1:0] op,
                                      input logic [drs_pkg::CHUNK_W-1:0] chunk,
                                      output drs_pkg::res_t r);
    int pos;
    pos = -1;
    for (int i = 0; i < held_q.size(); i++) begin
      if (pos < 0 && held_q[i] == chunk) pos = i;
    end
    r.push_ok      = 1'b1;
    r.popped_value = '0;
    case (op)
      drs_pkg::OP_PUSH: begin
        // a full store refuses even a number it already holds
        if (held_q.size() >= CAPACITY) r.push_ok = 1'b0;
        else if (pos < 0) held_q.push_back(chunk);
      end
      drs_pkg::OP_POP: begin
        if (held_q.size() > 0) r.popped_value = held_q.pop_back();
      end
      drs_pkg::OP_REMOVE: begin
        if (pos >= 0) held_q.delete(pos);
      end
      default: held_q.delete();
    endcase
    r.entry_count = drs_pkg::CNT_W'(held_q.size());
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_request(input logic [drs_pkg::TYPE_W-1:0] op,
                              input logic [drs_pkg::CHUNK_W-1:0] chunk,
                              input bit typed, input drs_pkg::res_t typed_res);
    drs_pkg::res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = chunk;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_stack_result(op, chunk, r);
    if (typed) r = typed_res;
    pending_results_q.push_back(r);
    @(negedge clk_i);
  endtask

  // receiver: random stall bursts, always ready when calm
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 18);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // result checker: every accepted word against the oldest pending prediction
  always @(posedge clk_i) begin
    drs_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result word %h at %0t", m_axis_tdata, $realtime);
      end else begin
        want = pending_results_q.pop_front();
        if (m_axis_tdata[0] !== want.push_ok ||
            m_axis_tdata[16:1] !== want.popped_value ||
            m_axis_tdata[21:17] !== want.entry_count ||
            m_axis_tdata[23:22] !== 2'b00) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch at %0t: want %0d/%h/%0d, got %0d/%h/%0d pad=%b",
                     $realtime, want.push_ok, want.popped_value, want.entry_count,
                     m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[21:17],
                     m_axis_tdata[23:22]);
        end
      end
    end
  end

  initial begin
    stim_row_t                   rows[$];
    drs_pkg::res_t               no_res;
    logic [drs_pkg::TYPE_W-1:0]  op;
    logic [drs_pkg::CHUNK_W-1:0] chunk;
    int                          roll;
    bit                          grow;

    no_res        = '0;
    mismatch_cnt  = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = drs_pkg::OP_PUSH;

    // directed rows: typed results only where obvious, the rest from the predictor
    rows = '{
      '{drs_pkg::OP_POP,    16'hBEEF, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},  // pop when empty
      '{drs_pkg::OP_REMOVE, 16'h1234, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},  // remove on empty
      '{drs_pkg::OP_PUSH,   16'h0000, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd1}},
      '{drs_pkg::OP_PUSH,   16'hFFFF, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd2}},
      '{drs_pkg::OP_PUSH,   16'hFFFF, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd2}},  // already held
      '{drs_pkg::OP_POP,    16'h0000, 1, 0, 1'b1, '{1'b1, 16'hFFFF, 5'd1}},
      '{drs_pkg::OP_POP,    16'hFFFF, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},
      '{drs_pkg::OP_POP,    16'h0000, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},
      '{drs_pkg::OP_PUSH,   16'h5A5A, CAPACITY, 16'h0101, 1'b0, no_res},  // fill to capacity
      '{drs_pkg::OP_PUSH,   16'hA5A5, 1, 0, 1'b1, '{1'b0, 16'h0000, 5'd16}}, // full, new
      '{drs_pkg::OP_PUSH,   16'h5A5A, 1, 0, 1'b1, '{1'b0, 16'h0000, 5'd16}}, // full, held
      '{drs_pkg::OP_REMOVE, 16'h5F5F, 1, 0, 1'b0, no_res},                 // middle entry
      '{drs_pkg::OP_REMOVE, 16'h5A5A, 1, 0, 1'b0, no_res},                 // oldest entry
      '{drs_pkg::OP_REMOVE, 16'hFFFF, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd14}}, // absent
      '{drs_pkg::OP_POP,    16'h0000, 1, 0, 1'b0, no_res},
      '{drs_pkg::OP_PUSH,   16'h0000, 1, 0, 1'b0, no_res},
      '{drs_pkg::OP_CLEAR,  16'hFFFF, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},
      '{drs_pkg::OP_POP,    16'h0000, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},  // nothing left
      '{drs_pkg::OP_CLEAR,  16'h0000, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}},  // clear when empty
      '{drs_pkg::OP_PUSH,   16'hAAAA, 1, 0, 1'b0, no_res},
      '{drs_pkg::OP_PUSH,   16'h5555, 1, 0, 1'b0, no_res},
      '{drs_pkg::OP_REMOVE, 16'h5555, 1, 0, 1'b0, no_res},                 // newest entry
      '{drs_pkg::OP_CLEAR,  16'h0000, 1, 0, 1'b1, '{1'b1, 16'h0000, 5'd0}}
    };

    // small pool so duplicates and remove hits are frequent
    foreach (chunk_pool[i]) chunk_pool[i] = drs_pkg::CHUNK_W'($urandom);
    chunk_pool[0] = 16'h0000;
    chunk_pool[1] = 16'hFFFF;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) begin
      for (int k = 0; k < rows[r].reps; k++)
        send_request(rows[r].op, rows[r].chunk + drs_pkg::CHUNK_W'(k * rows[r].step),
                     rows[r].typed, rows[r].res);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // calm windows, and a calm tail at the end
      calm = (i >= RAND_ITEMS - CALM_TAIL) || ((i / 50) % 4 == 3);
      // alternate push-heavy and pop-heavy stretches so full and empty both occur
      grow = ((i / 80) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (grow)
        op = (roll < 60) ? drs_pkg::OP_PUSH : (roll < 75) ? drs_pkg::OP_POP :
             (roll < 97) ? drs_pkg::OP_REMOVE : drs_pkg::OP_CLEAR;
      else
        op = (roll < 25) ? drs_pkg::OP_PUSH : (roll < 62) ? drs_pkg::OP_POP :
             (roll < 97) ? drs_pkg::OP_REMOVE : drs_pkg::OP_CLEAR;
      if (op == drs_pkg::OP_REMOVE && held_q.size() > 0 && $urandom_range(0, 3) != 0)
        chunk = held_q[$urandom_range(0, held_q.size() - 1)];
      else if ($urandom_range(0, 2) == 0)
        chunk = drs_pkg::CHUNK_W'($urandom);
      else
        chunk = chunk_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(op, chunk, 1'b0, no_res);
    end
    s_axis_tvalid = 1'b0;

    // drain, then give the block time to show any stray word
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    if (pending_results_q.size() != 0) mismatch_cnt++;

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
